FILE: sv/aavr_pkg.sv
// Shared constants and helpers for the axis-angle vector rotation core.
package aavr_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int ANGLE_BITS         = 17;

    // Angle units: 1/128 degree.
    localparam logic [18:0] FULL_TURN    = 19'd46080;
    localparam logic [13:0] QUARTER_TURN = 14'd11520;

    // Radians per angle unit, scaled by 2^36.
    localparam logic [37:0] RAD_PER_UNIT_Q36 = 38'd9370165;

    // 1.0 in the Q30 trigonometric format.
    localparam logic [30:0] TRIG_ONE  = 31'h4000_0000;
    localparam int          TRIG_FRAC = 30;
    localparam int          TRIG_STEPS = 6;

    // Series divisors, innermost term first, with exact reciprocals for
    // dividends below 2^32: q = (n * TRIG_M) >> TRIG_K.
    localparam logic [7:0] TRIG_DIV [TRIG_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam int TRIG_K [TRIG_STEPS] = '{40, 39, 39, 38, 37, 35};
    localparam logic [63:0] TRIG_M [TRIG_STEPS] = '{
        ((64'd1 << 40) + 64'd155) / 64'd156,
        ((64'd1 << 39) + 64'd109) / 64'd110,
        ((64'd1 << 39) + 64'd71)  / 64'd72,
        ((64'd1 << 38) + 64'd41)  / 64'd42,
        ((64'd1 << 37) + 64'd19)  / 64'd20,
        ((64'd1 << 35) + 64'd5)   / 64'd6
    };

    // Shift right by n with rounding half away from zero.
    function automatic logic signed [127:0] rnd_shr(input logic signed [127:0] p,
                                                    input int unsigned n);
        logic [127:0] mg;
        logic [127:0] r;
        mg = p[127] ? 128'(-p) : 128'(p);
        r  = (mg + (128'd1 << (n - 1))) >> n;
        return p[127] ? -$signed(r) : $signed(r);
    endfunction

endpackage

FILE: sv/aavr_if.sv
// Request and response channel interfaces of the rotation core.
interface aavr_in_if #(
    parameter int COMPONENT_BITS = aavr_pkg::COMPONENT_BITS_DEF
);
    logic                                    valid;
    logic                                    ready;
    logic signed [COMPONENT_BITS-1:0]        vec_x;
    logic signed [COMPONENT_BITS-1:0]        vec_y;
    logic signed [COMPONENT_BITS-1:0]        vec_z;
    logic signed [COMPONENT_BITS-1:0]        axis_x;
    logic signed [COMPONENT_BITS-1:0]        axis_y;
    logic signed [COMPONENT_BITS-1:0]        axis_z;
    logic signed [aavr_pkg::ANGLE_BITS-1:0]  angle_deg;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
                    output ready);
endinterface

interface aavr_out_if #(
    parameter int COMPONENT_BITS = aavr_pkg::COMPONENT_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] out_x;
    logic signed [COMPONENT_BITS-1:0] out_y;
    logic signed [COMPONENT_BITS-1:0] out_z;
    logic                             saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

FILE: sv/axis_angle_vector_rotation_core.sv
// Top level: pipelined Rodrigues rotation of a vector about an axis.
//
//   Channel  Direction  Handshake     Payload
//   i_req    in         valid/ready   vec_x/y/z, axis_x/y/z, angle_deg
//   o_rsp    out        valid/ready   out_x/y/z, saturated
//
// One request is taken every cycle while the output is not stalled; each result
// leaves through a pipeline whose depth is set by the six-term sine series, which
// spends one multiply stage and one reciprocal-divide stage on every term.
// Reset clears the valid bits only. A stalled output freezes every stage in
// step, so the input is held off only while the output register is full
// and not being taken.
module axis_angle_vector_rotation_core #(
    parameter int COMPONENT_BITS = aavr_pkg::COMPONENT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aavr_in_if.sink     i_req,
    aavr_out_if.source  o_rsp
);
    localparam int W   = COMPONENT_BITS;
    localparam int F   = W - 2;
    localparam int PW  = W + 2;
    localparam int DW  = W + 3;
    localparam int CW  = W + 3;
    localparam int TW  = 33;
    localparam int DDW = W + 4;
    localparam int SW  = W + 6;

    localparam int ST_X   = 2;
    localparam int ST_X2  = 3;
    localparam int ST_IT  = 4;
    localparam int ST_SIN = 16;
    localparam int ST_SEL = 17;
    localparam int ST_MUL = 18;
    localparam int ST_AD  = 19;
    localparam int ST_OUT = 20;
    localparam int NST    = 21;

    typedef logic signed [W-1:0] t_comp;

    localparam logic signed [SW-1:0] C_MAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [SW-1:0] C_MIN = ~C_MAX;

    logic en;
    logic r_vld [NST];

    assign en          = !r_vld[ST_OUT] || o_rsp.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_req.valid;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------- Angle reduction and quadrant split ----------------
    logic [18:0] n_m;
    logic [18:0] r_m;
    logic [18:0] ang_off;

    always_comb begin
        ang_off = 19'(20'($signed(i_req.angle_deg)) + 20'sd92160);
        if (ang_off >= 19'd138240)      n_m = ang_off - 19'd138240;
        else if (ang_off >= 19'd92160)  n_m = ang_off - 19'd92160;
        else if (ang_off >= aavr_pkg::FULL_TURN) n_m = ang_off - aavr_pkg::FULL_TURN;
        else                            n_m = ang_off;
    end

    logic [1:0]  n_quad;
    logic [13:0] n_u;
    logic [1:0]  r_quad [1:ST_SIN];
    logic [13:0] r_u    [2];

    always_comb begin
        if (r_m >= 19'd34560) begin
            n_quad = 2'd3; n_u = 14'(r_m - 19'd34560);
        end else if (r_m >= 19'd23040) begin
            n_quad = 2'd2; n_u = 14'(r_m - 19'd23040);
        end else if (r_m >= 19'(aavr_pkg::QUARTER_TURN)) begin
            n_quad = 2'd1; n_u = 14'(r_m - 19'(aavr_pkg::QUARTER_TURN));
        end else begin
            n_quad = 2'd0; n_u = r_m[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m       <= n_m;
            r_quad[1] <= n_quad;
            r_u[0]    <= n_u;
            r_u[1]    <= aavr_pkg::QUARTER_TURN - n_u;
            for (int k = 2; k <= ST_SIN; k++) r_quad[k] <= r_quad[k-1];
        end
    end

    // ---------------- Sine series, sine and cosine lanes ----------------
    logic [30:0] r_x  [ST_X:ST_SIN-1][2];
    logic [31:0] r_x2 [ST_X2:ST_SIN-3][2];
    logic [31:0] r_p  [aavr_pkg::TRIG_STEPS][2];
    logic [30:0] r_t  [aavr_pkg::TRIG_STEPS][2];
    logic [30:0] r_s0 [2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                r_x[ST_X][j] <= 31'((38'(r_u[j]) * aavr_pkg::RAD_PER_UNIT_Q36 + 38'd32) >> 6);
                for (int k = ST_X + 1; k <= ST_SIN - 1; k++) r_x[k][j] <= r_x[k-1][j];
                r_x2[ST_X2][j] <= 32'((62'(r_x[ST_X][j]) * 62'(r_x[ST_X][j])
                                      + 62'(aavr_pkg::TRIG_ONE >> 1)) >> aavr_pkg::TRIG_FRAC);
                for (int k = ST_X2 + 1; k <= ST_SIN - 3; k++) r_x2[k][j] <= r_x2[k-1][j];
            end
        end
    end

    for (genvar gi = 0; gi < aavr_pkg::TRIG_STEPS; gi++) begin : g_term
        for (genvar gj = 0; gj < 2; gj++) begin : g_lane
            logic [30:0] t_in;
            logic [31:0] num;
            logic [31:0] quo;
            if (gi == 0) begin : g_first
                assign t_in = aavr_pkg::TRIG_ONE;
            end else begin : g_next
                assign t_in = r_t[gi-1][gj];
            end
            assign num = r_p[gi][gj] + 32'(aavr_pkg::TRIG_DIV[gi] / 2);
            assign quo = 32'((65'(num) * 65'(aavr_pkg::TRIG_M[gi])) >> aavr_pkg::TRIG_K[gi]);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_p[gi][gj] <= 32'((63'(r_x2[ST_IT + 2*gi - 1][gj]) * 63'(t_in)
                                       + 63'(aavr_pkg::TRIG_ONE >> 1)) >> aavr_pkg::TRIG_FRAC);
                    r_t[gi][gj] <= (quo > 32'(aavr_pkg::TRIG_ONE)) ? 31'd0
                                 : 31'(32'(aavr_pkg::TRIG_ONE) - quo);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                logic [31:0] sv_raw;
                sv_raw = 32'((62'(r_x[ST_SIN-1][j]) * 62'(r_t[aavr_pkg::TRIG_STEPS-1][j])
                             + 62'(aavr_pkg::TRIG_ONE >> 1)) >> aavr_pkg::TRIG_FRAC);
                r_s0[j] <= (sv_raw > 32'(aavr_pkg::TRIG_ONE)) ? aavr_pkg::TRIG_ONE
                                                                : sv_raw[30:0];
            end
        end
    end

    // Quadrant symmetry: lane 0 holds sin(u), lane 1 holds cos(u).
    logic signed [TW-1:0] n_s, n_c, r_s, r_c, r_omc;
    logic signed [TW-1:0] s0, c0;

    assign s0 = $signed(TW'(r_s0[0]));
    assign c0 = $signed(TW'(r_s0[1]));

    always_comb begin
        case (r_quad[ST_SIN])
            2'd0:    begin n_s = s0;  n_c = c0;  end
            2'd1:    begin n_s = c0;  n_c = -s0; end
            2'd2:    begin n_s = -s0; n_c = -c0; end
            default: begin n_s = -c0; n_c = s0;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s   <= n_s;
            r_c   <= n_c;
            r_omc <= $signed(TW'(aavr_pkg::TRIG_ONE)) - n_c;
        end
    end

    // ---------------- Dot and cross products ----------------
    t_comp in_v [3];
    t_comp in_a [3];
    logic signed [2*W-1:0] m_av [3][3];
    logic signed [PW-1:0]  r_pr [3][3];

    assign in_v[0] = i_req.vec_x;
    assign in_v[1] = i_req.vec_y;
    assign in_v[2] = i_req.vec_z;
    assign in_a[0] = i_req.axis_x;
    assign in_a[1] = i_req.axis_y;
    assign in_a[2] = i_req.axis_z;

    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m_av[i][j] = in_a[i] * in_v[j];
    end

    t_comp               r_v_d  [0:ST_SEL][3];
    t_comp               r_a_d  [0:ST_MUL][3];
    logic signed [DW-1:0] r_d_d  [1:ST_SEL];
    logic signed [CW-1:0] r_cr_d [1:ST_SEL][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++)
                    r_pr[i][j] <= PW'(aavr_pkg::rnd_shr(128'(m_av[i][j]), F));
                r_v_d[0][i] <= in_v[i];
                r_a_d[0][i] <= in_a[i];
                for (int k = 1; k <= ST_SEL; k++) r_v_d[k][i] <= r_v_d[k-1][i];
                for (int k = 1; k <= ST_MUL; k++) r_a_d[k][i] <= r_a_d[k-1][i];
            end
            r_d_d[1] <= DW'(r_pr[0][0]) + DW'(r_pr[1][1]) + DW'(r_pr[2][2]);
            r_cr_d[1][0] <= CW'(r_pr[1][2]) - CW'(r_pr[2][1]);
            r_cr_d[1][1] <= CW'(r_pr[2][0]) - CW'(r_pr[0][2]);
            r_cr_d[1][2] <= CW'(r_pr[0][1]) - CW'(r_pr[1][0]);
            for (int k = 2; k <= ST_SEL; k++) begin
                r_d_d[k] <= r_d_d[k-1];
                for (int i = 0; i < 3; i++) r_cr_d[k][i] <= r_cr_d[k-1][i];
            end
        end
    end

    // ---------------- Rodrigues combination ----------------
    logic signed [DW+TW-1:0] m_domc;
    logic signed [W+TW-1:0]  m_vc [3];
    logic signed [CW+TW-1:0] m_cs [3];
    logic signed [W+DDW-1:0] m_ad [3];
    logic signed [DDW-1:0]   r_dd;
    logic signed [W+1:0]     r_vc [3];
    logic signed [CW-1:0]    r_cs [3];
    logic signed [SW-1:0]    r_vcs [3];
    logic signed [SW-1:0]    r_ad  [3];
    logic signed [SW-1:0]    sum   [3];
    t_comp                   r_out [3];
    logic                    r_sat;
    logic                    n_sat;
    t_comp                   n_out [3];

    always_comb begin
        m_domc = r_d_d[ST_SEL] * r_omc;
        for (int i = 0; i < 3; i++) begin
            m_vc[i] = r_v_d[ST_SEL][i] * r_c;
            m_cs[i] = r_cr_d[ST_SEL][i] * r_s;
            m_ad[i] = r_a_d[ST_MUL][i] * r_dd;
        end
    end

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sum[i] = r_vcs[i] + r_ad[i];
            if (sum[i] > C_MAX) begin
                n_out[i] = W'(C_MAX);
                n_sat    = 1'b1;
            end else if (sum[i] < C_MIN) begin
                n_out[i] = W'(C_MIN);
                n_sat    = 1'b1;
            end else begin
                n_out[i] = W'(sum[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd <= DDW'(aavr_pkg::rnd_shr(128'(m_domc), aavr_pkg::TRIG_FRAC));
            for (int i = 0; i < 3; i++) begin
                r_vc[i]  <= (W+2)'(aavr_pkg::rnd_shr(128'(m_vc[i]), aavr_pkg::TRIG_FRAC));
                r_cs[i]  <= CW'(aavr_pkg::rnd_shr(128'(m_cs[i]), aavr_pkg::TRIG_FRAC));
                r_vcs[i] <= SW'(r_vc[i]) + SW'(r_cs[i]);
                r_ad[i]  <= SW'(aavr_pkg::rnd_shr(128'(m_ad[i]), F));
                r_out[i] <= n_out[i];
            end
            r_sat <= n_sat;
        end
    end

    assign o_rsp.valid     = r_vld[ST_OUT];
    assign o_rsp.out_x     = r_out[0];
    assign o_rsp.out_y     = r_out[1];
    assign o_rsp.out_z     = r_out[2];
    assign o_rsp.saturated = r_sat;

    // ---------------- Assertions ----------------
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("input taken while the output stalls");

    a_valid_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[ST_MUL]) |=> r_vld[ST_AD])
        else $error("valid bit lost between stages");

    a_trig_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_SEL] |-> (r_s <= $signed(TW'(aavr_pkg::TRIG_ONE))
                       && r_s >= -$signed(TW'(aavr_pkg::TRIG_ONE))
                       && r_c <= $signed(TW'(aavr_pkg::TRIG_ONE))
                       && r_c >= -$signed(TW'(aavr_pkg::TRIG_ONE))))
        else $error("sine or cosine beyond unity");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.saturated) |->
            (o_rsp.out_x == W'(C_MAX) || o_rsp.out_x == W'(C_MIN)
          || o_rsp.out_y == W'(C_MAX) || o_rsp.out_y == W'(C_MIN)
          || o_rsp.out_z == W'(C_MAX) || o_rsp.out_z == W'(C_MIN)))
        else $error("saturation flagged with no clamped component");

endmodule

FILE: bench/axis_angle_vector_rotation_core_tb.sv
// Self-checking testbench for the axis-angle vector rotation core.
`timescale 1ns / 1ps

module axis_angle_vector_rotation_core_tb;

    localparam int CB = aavr_pkg::COMPONENT_BITS_DEF;
    localparam int FB = CB - 2;
    localparam int AB = aavr_pkg::ANGLE_BITS;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 sat;
    } t_rotation;

    // Round a*b / 2^n half away from zero.
    function automatic longint scaled_product(longint a, longint b, int n);
        logic signed [127:0] p;
        logic [127:0] m;
        p = 128'(a) * 128'(b);
        m = p[127] ? -p : p;
        m = (m + (128'd1 << (n - 1))) >> n;
        return p[127] ? -longint'(m) : longint'(m);
    endfunction

    // First-quadrant sine of u/128 degrees, Q30.
    function automatic longint quadrant_sine(longint u);
        longint divisor [6];
        longint x, x2, t, p, q, s;
        divisor = '{156, 110, 72, 42, 20, 6};
        x  = (u * 9370165 + 32) >>> 6;
        x2 = (x * x + (64'sd1 << 29)) >>> 30;
        t  = 64'sd1 << 30;
        for (int i = 0; i < 6; i++) begin
            p = (x2 * t + (64'sd1 << 29)) >>> 30;
            q = (p + divisor[i] / 2) / divisor[i];
            t = (q > (64'sd1 << 30)) ? 0 : (64'sd1 << 30) - q;
        end
        s = (x * t + (64'sd1 << 29)) >>> 30;
        return (s > (64'sd1 << 30)) ? (64'sd1 << 30) : s;
    endfunction

    function automatic t_rotation rotate_vector(longint v [3], longint a [3], longint ang);
        longint m, u, s0, c0, s, c, d, sum;
        longint cr [3];
        longint r [3];
        longint hi, lo;
        t_rotation res;
        hi = (64'sd1 <<< (CB - 1)) - 1;
        lo = -hi - 1;
        m = ang % 46080;
        if (m < 0) m += 46080;
        u = m % 11520;
        s0 = quadrant_sine(u);
        c0 = quadrant_sine(11520 - u);
        case (m / 11520)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
        d = scaled_product(a[0], v[0], FB) + scaled_product(a[1], v[1], FB)
          + scaled_product(a[2], v[2], FB);
        cr[0] = scaled_product(a[1], v[2], FB) - scaled_product(a[2], v[1], FB);
        cr[1] = scaled_product(a[2], v[0], FB) - scaled_product(a[0], v[2], FB);
        cr[2] = scaled_product(a[0], v[1], FB) - scaled_product(a[1], v[0], FB);
        d = scaled_product(d, (64'sd1 << 30) - c, 30);
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sum = scaled_product(v[i], c, 30) + scaled_product(cr[i], s, 30)
                + scaled_product(a[i], d, FB);
            if (sum > hi) begin sum = hi; res.sat = 1'b1; end
            if (sum < lo) begin sum = lo; res.sat = 1'b1; end
            r[i] = sum;
        end
        res.x = r[0][CB-1:0];
        res.y = r[1][CB-1:0];
        res.z = r[2][CB-1:0];
        return res;
    endfunction

    class rotation_scoreboard;
        t_rotation pending [$];
        int        mismatches;

        function void note_request(longint v [3], longint a [3], longint ang);
            pending.push_back(rotate_vector(v, a, ang));
        endfunction

        function void check_result(t_rotation got);
            t_rotation want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;
    rotation_scoreboard board;

    aavr_in_if  #(.COMPONENT_BITS(CB)) req_if ();
    aavr_out_if #(.COMPONENT_BITS(CB)) rsp_if ();

    axis_angle_vector_rotation_core #(.COMPONENT_BITS(CB)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.vec_x = '0; req_if.vec_y = '0; req_if.vec_z = '0;
        req_if.axis_x = '0; req_if.axis_y = '0; req_if.axis_z = '0;
        req_if.angle_deg = '0;
        rsp_if.ready = 1'b0;
    end

    // Sender: holds a request until it is taken, then perhaps pauses.
    task automatic send_request(longint v [3], longint a [3], longint ang);
        int gap;
        req_if.vec_x = CB'(v[0]); req_if.vec_y = CB'(v[1]); req_if.vec_z = CB'(v[2]);
        req_if.axis_x = CB'(a[0]); req_if.axis_y = CB'(a[1]); req_if.axis_z = CB'(a[2]);
        req_if.angle_deg = AB'(ang);
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_request(v, a, ang);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_if.valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic longint random_component();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return 16384;
            3: return -16384;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Receiver with random stall bursts.
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                rsp_if.ready = 1'b0;
                stall = $urandom_range(1, 12);
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            board.check_result('{rsp_if.out_x, rsp_if.out_y, rsp_if.out_z,
                                 rsp_if.saturated});

    initial begin
        longint v [3];
        longint a [3];
        longint ang;
        real    th, ph;
        longint dir_angles [12];
        board = new();
        dir_angles = '{0, 11520, 23040, 34560, 46080, -46080, -11520, 1, -1,
                       5760, 46079, -65536};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: axis extremes and every quadrant boundary, wrap cases.
        foreach (dir_angles[k]) begin
            v = '{16384, -8192, 4096};
            a = '{0, 0, 16384};
            send_request(v, a, dir_angles[k]);
        end
        v = '{32767, 32767, 32767};   a = '{32767, 32767, 32767};   send_request(v, a, 65535);
        v = '{-32768, -32768, -32768}; a = '{-32768, -32768, -32768}; send_request(v, a, -65536);
        v = '{32767, -32768, 0};     a = '{-32768, 32767, 0};     send_request(v, a, 23040);
        v = '{0, 0, 0};              a = '{0, 0, 0};              send_request(v, a, 5000);
        v = '{16384, 0, 0};          a = '{16384, 0, 0};          send_request(v, a, 17280);
        v = '{0, 16384, 0};          a = '{0, 0, 0};              send_request(v, a, 34560);

        for (int n = 0; n < 700; n++) begin
            if (n == 600) calm = 1'b1;
            if ($urandom_range(0, 2) != 0) begin
                // Unit axis with random vector, typical usage.
                th = $urandom_range(0, 62831) / 10000.0;
                ph = $urandom_range(0, 31415) / 10000.0;
                a = '{longint'($rtoi(16384.0 * $sin(ph) * $cos(th))),
                      longint'($rtoi(16384.0 * $sin(ph) * $sin(th))),
                      longint'($rtoi(16384.0 * $cos(ph)))};
                v = '{$signed(16'($urandom())) >>> 1, $signed(16'($urandom())) >>> 1,
                      $signed(16'($urandom())) >>> 1};
                ang = longint'($urandom_range(0, 92160)) - 46080;
            end else begin
                v = '{random_component(), random_component(), random_component()};
                a = '{random_component(), random_component(), random_component()};
                ang = $signed(17'($urandom()));
            end
            send_request(v, a, ang);
        end
        req_if.valid = 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule
